[rtl/stc_pkg.sv]
`default_nettype none

package stc_pkg;

    // Field widths
    localparam int TEMP_W     = 12;
    localparam int THYST_W    = 9;
    localparam int CHG_W      = 14;
    localparam int CHYST_W    = 10;
    localparam int MASK_W     = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HYST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_MID  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_HYST = 3'd5;

    // Register reset values
    localparam logic signed [TEMP_W-1:0] RST_TEMP_LIMIT  = 12'sd650;
    localparam logic [THYST_W-1:0]       RST_TEMP_HYST   = 9'd50;
    localparam logic [CHG_W-1:0]         RST_CHARGE_HIGH = 14'd9990;
    localparam logic [CHG_W-1:0]         RST_CHARGE_MID  = 14'd9900;
    localparam logic [CHG_W-1:0]         RST_CHARGE_LOW  = 14'd9800;
    localparam logic [CHYST_W-1:0]       RST_CHARGE_HYST = 10'd50;

    localparam logic [MASK_W-1:0] RST_MASK = 3'b111;

    // Charge mode
    typedef enum logic [MODE_W-1:0] {
        MODE_ALL_ON  = 2'd0,
        MODE_TWO_ON  = 2'd1,
        MODE_ALL_OFF = 2'd2
    } t_mode;

    typedef logic signed [TEMP_W-1:0] t_temp;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_limit;
        logic [THYST_W-1:0]       temp_hyst;
        logic [CHG_W-1:0]         charge_high;
        logic [CHG_W-1:0]         charge_mid;
        logic [CHG_W-1:0]         charge_low;
        logic [CHYST_W-1:0]       charge_hyst;
    } t_cfg;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_a;
        logic signed [TEMP_W-1:0] temp_b;
        logic signed [TEMP_W-1:0] temp_c;
        logic [CHG_W-1:0]         charge_level;
    } t_poll;

    typedef struct packed {
        logic [MASK_W-1:0] enables;
        t_mode             mode;
    } t_result;

endpackage

`default_nettype wire

[rtl/stc_in_if.sv]
`default_nettype none

interface stc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [stc_pkg::TEMP_W-1:0]   temp_a;
    logic signed [stc_pkg::TEMP_W-1:0]   temp_b;
    logic signed [stc_pkg::TEMP_W-1:0]   temp_c;
    logic [stc_pkg::CHG_W-1:0]           charge_level;

    modport source (output valid, output temp_a, output temp_b, output temp_c,
                    output charge_level, input ready);
    modport sink (input valid, input temp_a, input temp_b, input temp_c,
                  input charge_level, output ready);
endinterface

`default_nettype wire

[rtl/stc_out_if.sv]
`default_nettype none

interface stc_out_if;
    logic                          valid;
    logic                          ready;
    logic [stc_pkg::MASK_W-1:0]    enables;
    logic [stc_pkg::MODE_W-1:0]    mode;

    modport source (output valid, output enables, output mode, input ready);
    modport sink (input valid, input enables, input mode, output ready);
endinterface

`default_nettype wire

[rtl/stc_config.sv]
`default_nettype none

module stc_config (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [stc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [stc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output stc_pkg::t_cfg                           o_cfg
);

    stc_pkg::t_cfg r_cfg;

    // Register file; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_limit  <= stc_pkg::RST_TEMP_LIMIT;
            r_cfg.temp_hyst   <= stc_pkg::RST_TEMP_HYST;
            r_cfg.charge_high <= stc_pkg::RST_CHARGE_HIGH;
            r_cfg.charge_mid  <= stc_pkg::RST_CHARGE_MID;
            r_cfg.charge_low  <= stc_pkg::RST_CHARGE_LOW;
            r_cfg.charge_hyst <= stc_pkg::RST_CHARGE_HYST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                stc_pkg::CFG_TEMP_LIMIT:
                    r_cfg.temp_limit <= signed'(i_cfg_data[stc_pkg::TEMP_W-1:0]);
                stc_pkg::CFG_TEMP_HYST:
                    r_cfg.temp_hyst <= i_cfg_data[stc_pkg::THYST_W-1:0];
                stc_pkg::CFG_CHARGE_HIGH:
                    r_cfg.charge_high <= i_cfg_data[stc_pkg::CHG_W-1:0];
                stc_pkg::CFG_CHARGE_MID:
                    r_cfg.charge_mid <= i_cfg_data[stc_pkg::CHG_W-1:0];
                stc_pkg::CFG_CHARGE_LOW:
                    r_cfg.charge_low <= i_cfg_data[stc_pkg::CHG_W-1:0];
                stc_pkg::CFG_CHARGE_HYST:
                    r_cfg.charge_hyst <= i_cfg_data[stc_pkg::CHYST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/stc_engine.sv]
`default_nettype none

// Holds the charge mode and enable mask and computes one poll's update.
module stc_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire stc_pkg::t_cfg   i_cfg,
    input  wire stc_pkg::t_poll  i_poll,
    output stc_pkg::t_result     o_result
);

    stc_pkg::t_mode               r_mode, n_mode;
    logic [stc_pkg::MASK_W-1:0]   r_mask, n_mask;

    logic signed [13:0] hot_th, cool_th;
    logic signed [15:0] chg, chg_high, mid_lo, mid_hi, low_lo;
    stc_pkg::t_temp     t [3];
    logic [2:0]         hot_bits, cool_bits;
    logic [2:0]         m_cooled;
    logic [1:0]         cnt;

    // Temperature thresholds at full precision
    assign hot_th  = 14'(i_cfg.temp_limit) + signed'(14'(i_cfg.temp_hyst));
    assign cool_th = 14'(i_cfg.temp_limit) - signed'(14'(i_cfg.temp_hyst));

    assign t[0] = i_poll.temp_a;
    assign t[1] = i_poll.temp_b;
    assign t[2] = i_poll.temp_c;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            hot_bits[k]  = 14'(t[k]) > hot_th;
            cool_bits[k] = 14'(t[k]) < cool_th;
        end
    end

    // Overheated channels drop out first
    assign m_cooled = r_mask & ~hot_bits;
    assign cnt      = 2'($countones(m_cooled));

    // Charge thresholds
    assign chg      = signed'(16'(i_poll.charge_level));
    assign chg_high = signed'(16'(i_cfg.charge_high));
    assign mid_lo   = signed'(16'(i_cfg.charge_mid)) - signed'(16'(i_cfg.charge_hyst));
    assign mid_hi   = signed'(16'(i_cfg.charge_mid)) + signed'(16'(i_cfg.charge_hyst));
    assign low_lo   = signed'(16'(i_cfg.charge_low)) - signed'(16'(i_cfg.charge_hyst));

    // Mode chain, first match wins
    always_comb begin
        n_mode = r_mode;
        priority if (chg > chg_high) begin
            n_mode = stc_pkg::MODE_ALL_OFF;
        end else if (chg < mid_lo && r_mode == stc_pkg::MODE_ALL_OFF) begin
            n_mode = stc_pkg::MODE_TWO_ON;
        end else if (chg < low_lo && r_mode == stc_pkg::MODE_TWO_ON) begin
            n_mode = stc_pkg::MODE_ALL_ON;
        end else if (chg > mid_hi && r_mode == stc_pkg::MODE_ALL_ON) begin
            n_mode = stc_pkg::MODE_TWO_ON;
        end else begin
            n_mode = r_mode;
        end
    end

    // Three-compare exchange sort, then pick the two coolest eligible
    stc_pkg::t_temp      s [3];
    logic [1:0]          c [3];
    logic [2:0]          sc;
    logic signed [12:0]  gap;
    logic                allow;
    logic [2:0]          pick;
    logic [2:0]          two_mask;

    always_comb begin
        stc_pkg::t_temp tt;
        logic [1:0]     tc;
        tt = '0;
        tc = '0;
        s[0] = t[0]; s[1] = t[1]; s[2] = t[2];
        c[0] = 2'd0; c[1] = 2'd1; c[2] = 2'd2;
        if (s[1] < s[0]) begin
            tt = s[0]; tc = c[0]; s[0] = s[1]; c[0] = c[1]; s[1] = tt; c[1] = tc;
        end
        if (s[2] < s[0]) begin
            tt = s[0]; tc = c[0]; s[0] = s[2]; c[0] = c[2]; s[2] = tt; c[2] = tc;
        end
        if (s[2] < s[1]) begin
            tt = s[1]; tc = c[1]; s[1] = s[2]; c[1] = c[2]; s[2] = tt; c[2] = tc;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sc[i] = 14'(s[i]) < cool_th;
        end
    end

    assign gap   = 13'(s[2]) - 13'(s[1]);
    assign allow = (cnt == 2'd3) || (cnt == 2'd2 && gap > signed'(13'(i_cfg.temp_hyst)));
    assign pick  = {sc[2] && !(sc[0] && sc[1]), sc[1], sc[0]};

    always_comb begin
        two_mask = '0;
        for (int i = 0; i < 3; i++) begin
            if (allow && pick[i]) begin
                two_mask[c[i]] = 1'b1;
            end
        end
    end

    // Mask rebuild for the new mode
    always_comb begin
        unique case (n_mode)
            stc_pkg::MODE_ALL_OFF: n_mask = '0;
            stc_pkg::MODE_ALL_ON:  n_mask = m_cooled | cool_bits;
            stc_pkg::MODE_TWO_ON:  n_mask = two_mask;
            default:               n_mask = m_cooled;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= stc_pkg::MODE_ALL_ON;
            r_mask <= stc_pkg::RST_MASK;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_mask <= n_mask;
        end
    end

    assign o_result.enables = n_mask;
    assign o_result.mode    = n_mode;

    // All-off never jumps straight to all-on
    a_no_mode_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == stc_pkg::MODE_ALL_OFF |=> r_mode != stc_pkg::MODE_ALL_ON)
        else $error("mode skipped two-on");

endmodule

`default_nettype wire

[rtl/solar_tracker_thermal_charge_control_core.sv]
// An accepted poll item waits in the input register and moves on to the result
// register, where its result is offered, once that register is free.
// Throughput: one item per cycle unless the result side stalls; input and result
// registers decouple the sides, and the mode/mask update is a single combinational pass.
// Reset (synchronous, active low): mode all-on, all three channels enabled,
// configuration registers at their defaults, both pipeline registers empty.
`default_nettype none

module solar_tracker_thermal_charge_control_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    stc_in_if.sink                                 i_in,
    stc_out_if.source                              o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [stc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [stc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    stc_pkg::t_cfg     cfg;
    stc_pkg::t_result  result;
    stc_pkg::t_poll    r_poll;
    logic              r_in_valid;
    logic              r_out_valid;
    stc_pkg::t_result  r_out;
    logic              step;
    logic              in_take;

    stc_config u_config (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Item moves from input register to result register
    assign step    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;
    assign in_take = i_in.valid && i_in.ready;

    stc_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cfg    (cfg),
        .i_poll   (r_poll),
        .o_result (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_poll.temp_a       <= i_in.temp_a;
            r_poll.temp_b       <= i_in.temp_b;
            r_poll.temp_c       <= i_in.temp_c;
            r_poll.charge_level <= i_in.charge_level;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.enables = r_out.enables;
    assign o_out.mode    = r_out.mode;

    // All-off results carry an empty mask
    a_off_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.mode == stc_pkg::MODE_ALL_OFF |-> r_out.enables == '0)
        else $error("channels enabled in all-off mode");

    // Two-on mode never enables more than two channels
    a_two_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.mode == stc_pkg::MODE_TWO_ON |-> $countones(r_out.enables) <= 2)
        else $error("more than two channels in two-on mode");

    // A held item reaches the result register once it is free
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && (!r_out_valid || o_out.ready) |=> r_out_valid)
        else $error("item did not advance");

endmodule

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
    import stc_pkg::*;

    // Indexes past the last register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int N_DIRECTED      = 22;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int SETTLE_CYCLES   = 10;

    typedef struct packed {
        t_poll   poll;
        logic    known;
        t_result want;
    } t_row;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    stc_in_if  poll_if ();
    stc_out_if res_if ();

    solar_tracker_thermal_charge_control_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (poll_if),
        .o_out      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    // Shadow of the controller: registers, charge mode and channel mask
    t_cfg              ctl_cfg;
    t_mode             switch_mode;
    logic [MASK_W-1:0] switch_mask;
    t_result           expected_switches[$];

    int src_gap_pct       = 8;
    int sink_stall_pct    = 55;
    int sink_hold_cycles  = 0;
    int polls_sent        = 0;
    int results_checked   = 0;
    int mismatches        = 0;
    int settings_used     = 0;
    int last_charge       = 0;
    int mode_hits[3]      = '{0, 0, 0};

    function automatic int clamp(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Update the register shadow the same way the block decodes a write
    function automatic void cfg_shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_TEMP_LIMIT:  ctl_cfg.temp_limit  = data[TEMP_W-1:0];
            CFG_TEMP_HYST:   ctl_cfg.temp_hyst   = data[THYST_W-1:0];
            CFG_CHARGE_HIGH: ctl_cfg.charge_high = data[CHG_W-1:0];
            CFG_CHARGE_MID:  ctl_cfg.charge_mid  = data[CHG_W-1:0];
            CFG_CHARGE_LOW:  ctl_cfg.charge_low  = data[CHG_W-1:0];
            CFG_CHARGE_HYST: ctl_cfg.charge_hyst = data[CHYST_W-1:0];
            default: ;
        endcase
    endfunction

    // One poll: over-temp cut, mode chain, then mask rebuild for the mode
    function automatic t_result predict_switches(input t_poll p);
        int      t[3];
        int      srt[3];
        int      ch[3];
        int      lim, hot, cool, chg, hy, cnt, on, tv, tc, k, i, j;
        t_result r;
        t[0] = int'(p.temp_a);
        t[1] = int'(p.temp_b);
        t[2] = int'(p.temp_c);
        lim  = int'(ctl_cfg.temp_limit);
        hot  = lim + int'(ctl_cfg.temp_hyst);
        cool = lim - int'(ctl_cfg.temp_hyst);
        chg  = int'(p.charge_level);
        hy   = int'(ctl_cfg.charge_hyst);

        for (k = 0; k < 3; k++)
            if (t[k] > hot) switch_mask[k] = 1'b0;

        if (chg > int'(ctl_cfg.charge_high))
            switch_mode = MODE_ALL_OFF;
        else if (chg < int'(ctl_cfg.charge_mid) - hy && switch_mode == MODE_ALL_OFF)
            switch_mode = MODE_TWO_ON;
        else if (chg < int'(ctl_cfg.charge_low) - hy && switch_mode == MODE_TWO_ON)
            switch_mode = MODE_ALL_ON;
        else if (chg > int'(ctl_cfg.charge_mid) + hy && switch_mode == MODE_ALL_ON)
            switch_mode = MODE_TWO_ON;

        case (switch_mode)
            MODE_ALL_OFF: switch_mask = '0;
            MODE_ALL_ON: begin
                for (k = 0; k < 3; k++)
                    if (t[k] < cool) switch_mask[k] = 1'b1;
            end
            MODE_TWO_ON: begin
                cnt = int'(switch_mask[0]) + int'(switch_mask[1]) + int'(switch_mask[2]);
                for (k = 0; k < 3; k++) begin
                    srt[k] = t[k];
                    ch[k]  = k;
                end
                // exchange sort, later entry moves up only when strictly cooler
                for (i = 0; i < 2; i++)
                    for (j = i + 1; j < 3; j++)
                        if (srt[j] < srt[i]) begin
                            tv = srt[i]; tc = ch[i];
                            srt[i] = srt[j]; ch[i] = ch[j];
                            srt[j] = tv; ch[j] = tc;
                        end
                switch_mask = '0;
                if (cnt == 3 || (cnt == 2 && srt[2] - srt[1] > int'(ctl_cfg.temp_hyst))) begin
                    on = 0;
                    for (i = 0; i < 3 && on < 2; i++)
                        if (srt[i] < cool) begin
                            switch_mask[ch[i]] = 1'b1;
                            on++;
                        end
                end
            end
            default: ;
        endcase

        r.enables = switch_mask;
        r.mode    = switch_mode;
        return r;
    endfunction

    function automatic t_row mk_row(input int a, input int b, input int c, input int chg,
                                    input logic known, input int en, input t_mode md);
        t_row r;
        r.poll.temp_a       = t_temp'(a);
        r.poll.temp_b       = t_temp'(b);
        r.poll.temp_c       = t_temp'(c);
        r.poll.charge_level = chg[CHG_W-1:0];
        r.known             = known;
        r.want.enables      = en[MASK_W-1:0];
        r.want.mode         = md;
        return r;
    endfunction

    // Temperatures cluster on the cool and hot edges and on the limit, with some spread
    function automatic t_temp pick_temp();
        int lim, th, base, v;
        lim = int'(ctl_cfg.temp_limit);
        th  = int'(ctl_cfg.temp_hyst);
        case ($urandom_range(9))
            0:       v = int'($urandom_range(4095)) - 2048;
            1, 2:    v = int'($urandom_range(3000)) - 1000;
            default: begin
                case ($urandom_range(2))
                    0:       base = lim - th;
                    1:       base = lim + th;
                    default: base = lim;
                endcase
                v = base + int'($urandom_range(6)) - 3;
            end
        endcase
        return t_temp'(clamp(v, -2048, 2047));
    endfunction

    // Charge mostly walks from the last level or lands near the mode thresholds, so the chain gets exercised
    function automatic t_poll random_poll();
        t_poll p;
        int    hy, base, v;
        hy = int'(ctl_cfg.charge_hyst);
        p.temp_a = pick_temp();
        p.temp_b = pick_temp();
        p.temp_c = pick_temp();
        case ($urandom_range(9))
            0:       v = int'($urandom_range(16383));
            1:       v = int'($urandom_range(10000));
            2, 3, 4: begin
                case ($urandom_range(3))
                    0:       base = int'(ctl_cfg.charge_high);
                    1:       base = int'(ctl_cfg.charge_mid) - hy;
                    2:       base = int'(ctl_cfg.charge_mid) + hy;
                    default: base = int'(ctl_cfg.charge_low) - hy;
                endcase
                v = base + int'($urandom_range(8)) - 4;
            end
            default: v = last_charge + int'($urandom_range(120)) - 60;
        endcase
        v = clamp(v, 0, 16383);
        last_charge = v;
        p.charge_level = v[CHG_W-1:0];
        return p;
    endfunction

    // Register write; bits above the register width carry junk
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value,
                             input int width);
        logic [CFG_DATA_W-1:0] keep, data;
        keep = CFG_DATA_W'((1 << width) - 1);
        data = (CFG_DATA_W'(value) & keep) | (CFG_DATA_W'($urandom) & ~keep);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_shadow_write(idx, data);
    endtask

    task automatic apply_settings(input int lim, input int th, input int hi,
                                  input int mid, input int lo, input int ch);
        cfg_write(CFG_TEMP_LIMIT, lim, TEMP_W);
        cfg_write(CFG_TEMP_HYST, th, THYST_W);
        cfg_write(CFG_CHARGE_HIGH, hi, CHG_W);
        cfg_write(CFG_CHARGE_MID, mid, CHG_W);
        cfg_write(CFG_CHARGE_LOW, lo, CHG_W);
        cfg_write(CFG_CHARGE_HYST, ch, CHYST_W);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Offer one poll; on acceptance record what should come out
    task automatic send_poll(input t_poll p, input logic known, input t_result want);
        t_result predicted;
        while ($urandom_range(99) < src_gap_pct) begin
            poll_if.valid <= 1'b0;
            @(posedge clk);
        end
        poll_if.valid        <= 1'b1;
        poll_if.temp_a       <= p.temp_a;
        poll_if.temp_b       <= p.temp_b;
        poll_if.temp_c       <= p.temp_c;
        poll_if.charge_level <= p.charge_level;
        @(posedge clk);
        while (!poll_if.ready) @(posedge clk);
        predicted = predict_switches(p);
        expected_switches.push_back(known ? want : predicted);
        polls_sent++;
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (expected_switches.size() != 0);
    endtask

    // Result side: random back-pressure, long hold-off on request, compare
    initial begin
        t_result want;
        logic    take;
        forever begin
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                take = 1'b0;
            end else begin
                take = ($urandom_range(99) >= sink_stall_pct);
            end
            res_if.ready <= take;
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready) begin
                if (expected_switches.size() == 0) begin
                    $error("unexpected result: enables %0d mode %0d",
                           res_if.enables, res_if.mode);
                    mismatches++;
                end else begin
                    want = expected_switches.pop_front();
                    results_checked++;
                    mode_hits[want.mode]++;
                    if (res_if.enables !== want.enables) begin
                        $error("enables: expected %0d, got %0d", want.enables, res_if.enables);
                        mismatches++;
                    end
                    if (res_if.mode !== want.mode) begin
                        $error("mode: expected %0d, got %0d", want.mode, res_if.mode);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Main sequence
    initial begin
        t_row dir_table [N_DIRECTED];
        int   phase, n;

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= '0;
        cfg_data             <= '0;
        poll_if.valid        <= 1'b0;
        poll_if.temp_a       <= '0;
        poll_if.temp_b       <= '0;
        poll_if.temp_c       <= '0;
        poll_if.charge_level <= '0;

        ctl_cfg.temp_limit  = RST_TEMP_LIMIT;
        ctl_cfg.temp_hyst   = RST_TEMP_HYST;
        ctl_cfg.charge_high = RST_CHARGE_HIGH;
        ctl_cfg.charge_mid  = RST_CHARGE_MID;
        ctl_cfg.charge_low  = RST_CHARGE_LOW;
        ctl_cfg.charge_hyst = RST_CHARGE_HYST;
        switch_mode = MODE_ALL_ON;
        switch_mask = RST_MASK;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // writes to unused indexes must leave the defaults alone
        cfg_write(CFG_SPARE_LO, int'($urandom), CFG_DATA_W);
        cfg_write(CFG_SPARE_HI, int'($urandom), CFG_DATA_W);
        cfg_we <= 1'b0;

        // Directed polls at reset defaults: limit 65.0, cool below 60.0, hot above 70.0
        dir_table = '{
            mk_row(0, 0, 0, 0, 1'b1, 7, MODE_ALL_ON),
            mk_row(2047, 0, 0, 0, 1'b1, 6, MODE_ALL_ON),
            mk_row(-2048, -2048, -2048, 0, 1'b1, 7, MODE_ALL_ON),
            mk_row(0, 0, 0, 16383, 1'b1, 0, MODE_ALL_OFF),
            mk_row(0, 0, 0, 9850, 1'b0, 0, MODE_ALL_ON),
            mk_row(0, 0, 0, 9849, 1'b0, 0, MODE_ALL_ON),
            mk_row(0, 0, 0, 9750, 1'b0, 0, MODE_ALL_ON),
            mk_row(-1, -1, -1, 9749, 1'b0, 0, MODE_ALL_ON),
            mk_row(0, 0, 0, 9950, 1'b0, 0, MODE_ALL_ON),
            mk_row(100, 300, 200, 9951, 1'b0, 0, MODE_ALL_ON),
            mk_row(100, 900, 200, 9960, 1'b0, 0, MODE_ALL_ON),
            mk_row(100, 250, 200, 9960, 1'b0, 0, MODE_ALL_ON),
            mk_row(0, 0, 0, 0, 1'b0, 0, MODE_ALL_ON),
            mk_row(300, 300, 300, 9960, 1'b0, 0, MODE_ALL_ON),
            mk_row(300, 300, 2047, 9960, 1'b0, 0, MODE_ALL_ON),
            mk_row(700, 100, 500, 9960, 1'b0, 0, MODE_ALL_ON),
            mk_row(599, 600, 701, 0, 1'b0, 0, MODE_ALL_ON),
            mk_row(598, 599, 600, 9990, 1'b0, 0, MODE_ALL_ON),
            mk_row(0, 0, 0, 9991, 1'b1, 0, MODE_ALL_OFF),
            mk_row(2047, 2047, 2047, 9849, 1'b0, 0, MODE_ALL_ON),
            mk_row(-2048, 2047, -2048, 9749, 1'b0, 0, MODE_ALL_ON),
            mk_row(1365, -1366, 682, 10922, 1'b0, 0, MODE_ALL_ON)
        };
        foreach (dir_table[r])
            send_poll(dir_table[r].poll, dir_table[r].known, dir_table[r].want);
        poll_if.valid <= 1'b0;
        wait_drained();

        // Random phases, each under its own register setting
        for (phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: apply_settings(650, 50, 9990, 9900, 9800, 50);
                1: apply_settings(300, 100, 8000, 5000, 3000, 200);
                2: apply_settings(2047, 0, 16383, 0, 0, 0);
                3: apply_settings(-2048, 511, 0, 16383, 16383, 1023);
                4: apply_settings(-1000, 500, 10000, 10000, 10000, 1000);
                default: apply_settings(int'($urandom_range(3000)) - 1000,
                                        int'($urandom_range(500)),
                                        int'($urandom_range(10000)),
                                        int'($urandom_range(10000)),
                                        int'($urandom_range(10000)),
                                        int'($urandom_range(1000)));
            endcase
            src_gap_pct    = (phase < 2) ? 8 : (phase < 4) ? 55 : 0;
            sink_stall_pct = (phase < 2) ? 55 : (phase < 4) ? 8 : 0;

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // receiver blocks for a while; sender keeps pushing until stalled
                if (phase == 1 && n == ITEMS_PER_PHASE / 2) begin
                    src_gap_pct      = 0;
                    sink_hold_cycles = HOLD_OFF_CYCLES;
                end
                if (phase == 1 && n == ITEMS_PER_PHASE / 2 + 80)
                    src_gap_pct = 8;
                // sender stops until the pipeline is empty
                if (phase == 3 && n == ITEMS_PER_PHASE / 2) begin
                    poll_if.valid <= 1'b0;
                    wait_drained();
                end
                send_poll(random_poll(), 1'b0, '0);
            end
            poll_if.valid <= 1'b0;
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Ran %0d polls (%0d checked) over reset defaults and %0d register settings.",
                 polls_sent, results_checked, settings_used);
        $display("Results by mode: all-on %0d, two-on %0d, all-off %0d; mismatches %0d.",
                 mode_hits[MODE_ALL_ON], mode_hits[MODE_TWO_ON], mode_hits[MODE_ALL_OFF],
                 mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
